// ===== hdl/wspd_pkg.sv =====
// Shared types, constants and the control store of the wheel speed PID drive.
package wspd_pkg;

  // Saturation limits: integral at 150.0 in Q.15, output at 255.0 in Q.4.
  localparam int INTEG_LIMIT = 4915200;
  localparam int LEVEL_LIMIT = 4080;

  localparam int unsigned STEP_W = 4;
  typedef logic [STEP_W-1:0] step_t;

  // Step addresses of the control program.
  localparam step_t ST_IDLE   = 4'd0;
  localparam step_t ST_PREP   = 4'd1;
  localparam step_t ST_MUL_IT = 4'd2;
  localparam step_t ST_INTEG  = 4'd3;
  localparam step_t ST_ACC_P  = 4'd4;
  localparam step_t ST_KREG   = 4'd5;
  localparam step_t ST_ACC_I  = 4'd6;
  localparam step_t ST_ACC_D  = 4'd7;
  localparam step_t ST_MAG    = 4'd8;
  localparam step_t ST_SPAN   = 4'd9;
  localparam step_t ST_EMIT   = 4'd10;
  localparam step_t ST_STOP   = 4'd11;

  typedef enum logic [2:0] {
    REG_PROP_GAIN,
    REG_INTEG_GAIN,
    REG_DERIV_GAIN,
    REG_TICK_PERIOD,
    REG_TICK_RATE,
    REG_DUTY_FLOOR,
    REG_DUTY_CEILING,
    REG_REVERSE_WIRING
  } cfg_reg_t;

  typedef enum logic [2:0] {
    MUL_NONE,
    MUL_ERR_TP,
    MUL_KP_ERR,
    MUL_KD_TR,
    MUL_KI_INT,
    MUL_KDR_DIFF,
    MUL_MAG_SPAN
  } mul_sel_t;

  typedef enum logic [2:0] {
    ACC_HOLD,
    ACC_CLEAR,
    ACC_ADD0,
    ACC_ADD7,
    ACC_ADD11
  } acc_op_t;

  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_LATCH,
    ACT_PREP,
    ACT_INTEG,
    ACT_KREG,
    ACT_MAG,
    ACT_EMIT_RUN,
    ACT_EMIT_STOP
  } act_t;

  typedef enum logic [1:0] {
    JMP_NEXT,
    JMP_WAIT_IN,
    JMP_IF_STOP,
    JMP_WAIT_OUT
  } jmp_t;

  typedef struct packed {
    mul_sel_t mul;
    acc_op_t  acc;
    act_t     act;
    jmp_t     jmp;
    step_t    dest;
  } uword_t;

  // Conditions the datapath reports to the sequencer.
  typedef struct packed {
    logic in_fire;
    logic stop;
    logic out_free;
  } cond_t;

  function automatic uword_t rom_word(step_t s);
    uword_t w;
    unique case (s)
      ST_IDLE:   w = '{MUL_NONE,     ACC_HOLD,  ACT_LATCH,     JMP_WAIT_IN,  ST_IDLE};
      ST_PREP:   w = '{MUL_NONE,     ACC_HOLD,  ACT_PREP,      JMP_IF_STOP,  ST_STOP};
      ST_MUL_IT: w = '{MUL_ERR_TP,   ACC_HOLD,  ACT_NONE,      JMP_NEXT,     ST_IDLE};
      ST_INTEG:  w = '{MUL_KP_ERR,   ACC_CLEAR, ACT_INTEG,     JMP_NEXT,     ST_IDLE};
      ST_ACC_P:  w = '{MUL_KD_TR,    ACC_ADD11, ACT_NONE,      JMP_NEXT,     ST_IDLE};
      ST_KREG:   w = '{MUL_KI_INT,   ACC_HOLD,  ACT_KREG,      JMP_NEXT,     ST_IDLE};
      ST_ACC_I:  w = '{MUL_KDR_DIFF, ACC_ADD0,  ACT_NONE,      JMP_NEXT,     ST_IDLE};
      ST_ACC_D:  w = '{MUL_NONE,     ACC_ADD7,  ACT_NONE,      JMP_NEXT,     ST_IDLE};
      ST_MAG:    w = '{MUL_NONE,     ACC_HOLD,  ACT_MAG,       JMP_NEXT,     ST_IDLE};
      ST_SPAN:   w = '{MUL_MAG_SPAN, ACC_HOLD,  ACT_NONE,      JMP_NEXT,     ST_IDLE};
      ST_EMIT:   w = '{MUL_NONE,     ACC_HOLD,  ACT_EMIT_RUN,  JMP_WAIT_OUT, ST_IDLE};
      ST_STOP:   w = '{MUL_NONE,     ACC_HOLD,  ACT_EMIT_STOP, JMP_WAIT_OUT, ST_IDLE};
      default:   w = '{MUL_NONE,     ACC_HOLD,  ACT_NONE,      JMP_WAIT_OUT, ST_IDLE};
    endcase
    return w;
  endfunction

endpackage

// ===== hdl/wheel_speed_pid_pwm_drive.sv =====
// Top level of the wheel speed PID controller with PWM deadband mapping.
//
// One motor channel. Each word on the s_ channel is one control tick carrying
// the wheel setpoint, the measured speed and a trim term, all signed Q12.4 rpm.
// Each accepted word yields exactly one word on the m_ channel with the PWM
// duty, both direction pin levels, the clamped signed drive level and a flag
// that tells whether the stop path was taken.
// Gains, sample period, PWM limits and pin inversion are set through the
// write port (cfg_we, cfg_addr, cfg_wdata). The user must write them only
// while no tick is in flight; the block itself does not enforce this.
// A tick runs as a short microprogram on one shared 33x19 multiplier and one
// accumulator; the multiplier is used for six products in turn, and a stop
// tick jumps from the preparation step straight to its own final step.
// s_tready is high only when the sequencer is idle, so one tick is in flight
// at a time, but the result sits in its own register and the next word is
// accepted while it waits. If the receiver stalls, the following tick runs
// up to its final step and waits there for the register.
// Synchronous reset loads the register defaults and clears the integral, the
// last error and the stored setpoint, and empties the result register.
module wheel_speed_pid_pwm_drive (
  input  logic              clk,
  input  logic              rst,
  // Configuration writes.
  input  logic              cfg_we,
  input  wspd_pkg::cfg_reg_t cfg_addr,
  input  logic [15:0]       cfg_wdata,
  // Tick input.
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [47:0]       s_tdata,  // target_speed, measured_speed, trim_speed
  // Result output.
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [23:0]       m_tdata   // duty, dir_a, dir_b, drive_level, halted
);
  import wspd_pkg::*;

  localparam logic signed [30:0] IntegHi = 31'(INTEG_LIMIT);
  localparam logic signed [30:0] IntegLo = -IntegHi;

  // Configuration registers.
  logic [15:0] prop_gain;
  logic [15:0] integ_gain;
  logic [15:0] deriv_gain;
  logic [15:0] tick_period;
  logic [15:0] tick_rate;
  logic [7:0]  duty_floor;
  logic [7:0]  duty_ceiling;
  logic        reverse_wiring;

  // Controller history.
  logic signed [23:0] integ_acc;
  logic signed [17:0] prev_error;
  logic signed [15:0] prev_target;

  // Working registers of one tick.
  logic signed [15:0] tgt_r;
  logic signed [15:0] meas_r;
  logic signed [15:0] trim_r;
  logic signed [17:0] err_r;
  logic signed [18:0] diff_r;
  logic               sp_neg;
  logic [31:0]        kreg;
  logic signed [51:0] prod;
  logic signed [59:0] acc;
  logic [12:0]        mag;

  // Result register.
  logic [7:0]         out_duty;
  logic               out_dir_a;
  logic               out_dir_b;
  logic signed [12:0] out_level;
  logic               out_halted;

  step_t  step;
  uword_t uw;
  logic   adv;
  cond_t  cond;
  logic   in_fire;
  logic   out_free;

  assign s_tready = (step == ST_IDLE);
  assign in_fire  = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign m_tdata  = {out_halted, out_level, out_dir_b, out_dir_a, out_duty};

  // Setpoint, error and the history decisions of the preparation step.
  logic signed [16:0] sp;
  logic signed [17:0] err;
  logic signed [17:0] prev_err_eff;
  logic signed [18:0] diff;
  logic               changed;
  logic               stop;

  always_comb begin
    sp           = 17'(tgt_r) + 17'(trim_r);
    err          = 18'(sp) - 18'(meas_r);
    changed      = (tgt_r != prev_target);
    stop         = (sp == '0) && (tgt_r == '0);
    prev_err_eff = changed ? '0 : prev_error;
    diff         = 19'(err) - 19'(prev_err_eff);
  end

  assign cond = '{in_fire: in_fire, stop: stop, out_free: out_free};

  wspd_seq u_seq (
    .clk  (clk),
    .rst  (rst),
    .cond (cond),
    .step (step),
    .uw   (uw),
    .adv  (adv)
  );

  // Shared multiplier operand selection.
  logic signed [32:0] mul_a;
  logic signed [18:0] mul_b;
  logic signed [51:0] mul_p;
  logic signed [8:0]  span;

  assign span = $signed({1'b0, duty_ceiling}) - $signed({1'b0, duty_floor});

  always_comb begin
    case (uw.mul)
      MUL_ERR_TP: begin
        mul_a = 33'(err_r);
        mul_b = {3'b000, tick_period};
      end
      MUL_KP_ERR: begin
        mul_a = 33'(err_r);
        mul_b = {3'b000, prop_gain};
      end
      MUL_KD_TR: begin
        mul_a = {17'd0, deriv_gain};
        mul_b = {3'b000, tick_rate};
      end
      MUL_KI_INT: begin
        mul_a = 33'(integ_acc);
        mul_b = {3'b000, integ_gain};
      end
      MUL_KDR_DIFF: begin
        mul_a = {1'b0, kreg};
        mul_b = diff_r;
      end
      MUL_MAG_SPAN: begin
        mul_a = {20'd0, mag};
        mul_b = 19'(span);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // Integral update: the increment is err*Ts in Q.20 floored to Q.15.
  logic signed [29:0] integ_inc;
  logic signed [30:0] integ_sum;
  logic signed [23:0] integ_new;

  always_comb begin
    integ_inc = prod[34:5];
    integ_sum = 31'(integ_acc) + 31'(integ_inc);
    if (integ_sum > IntegHi) begin
      integ_new = IntegHi[23:0];
    end else if (integ_sum < IntegLo) begin
      integ_new = IntegLo[23:0];
    end else begin
      integ_new = integ_sum[23:0];
    end
  end

  // Output magnitude: |sum| truncated from Q.23 to Q.4, clamped to 255.0.
  logic [59:0] acc_abs;
  logic [40:0] acc_q4;
  logic [12:0] mag_new;

  always_comb begin
    acc_abs = acc[59] ? 60'(-acc) : 60'(acc);
    acc_q4  = acc_abs[59:19];
    mag_new = (acc_q4 > 41'(LEVEL_LIMIT)) ? 13'(LEVEL_LIMIT) : acc_q4[12:0];
  end

  // Duty mapping. The product mag*span is at most 255*4080 when span is not
  // negative, so dividing by 4080 is a shift by four followed by a division
  // by 255: an estimate through y*257/65536 is at most one low and one
  // compare fixes it.
  logic [15:0] dy;
  logic [24:0] dt;
  logic [7:0]  q0;
  logic [15:0] q0x255;
  logic [16:0] rem;
  logic [7:0]  dq;
  logic [7:0]  duty_new;
  logic        fwd;

  always_comb begin
    dy      = prod[19:4];
    dt      = {1'b0, dy, 8'd0} + 25'(dy);
    q0      = dt[23:16];
    q0x255  = {q0, 8'd0} - 16'(q0);
    rem     = {1'b0, dy} - {1'b0, q0x255};
    dq      = (rem >= 17'd255) ? q0 + 8'd1 : q0;
    if (mag == '0) begin
      duty_new = '0;
    end else if (prod[51]) begin
      duty_new = duty_floor;
    end else begin
      duty_new = duty_floor + dq;
    end
    fwd = !sp_neg ^ reverse_wiring;
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      prop_gain      <= 16'd256;
      integ_gain     <= 16'd0;
      deriv_gain     <= 16'd0;
      tick_period    <= 16'd3277;
      tick_rate      <= 16'd320;
      duty_floor     <= 8'd0;
      duty_ceiling   <= 8'd255;
      reverse_wiring <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_PROP_GAIN:      prop_gain      <= cfg_wdata;
        REG_INTEG_GAIN:     integ_gain     <= cfg_wdata;
        REG_DERIV_GAIN:     deriv_gain     <= cfg_wdata;
        REG_TICK_PERIOD:    tick_period    <= cfg_wdata;
        REG_TICK_RATE:      tick_rate      <= cfg_wdata;
        REG_DUTY_FLOOR:     duty_floor     <= cfg_wdata[7:0];
        REG_DUTY_CEILING:   duty_ceiling   <= cfg_wdata[7:0];
        REG_REVERSE_WIRING: reverse_wiring <= cfg_wdata[0];
      endcase
    end
  end

  // Controller history. A new setpoint wipes the integral, and its tick takes
  // the last error as zero; the stop path wipes both integral and last error.
  always_ff @(posedge clk) begin
    if (rst) begin
      integ_acc   <= '0;
      prev_error  <= '0;
      prev_target <= '0;
    end else if (uw.act == ACT_PREP) begin
      prev_target <= tgt_r;
      if (stop) begin
        integ_acc  <= '0;
        prev_error <= '0;
      end else begin
        prev_error <= err;
        if (changed) begin
          integ_acc <= '0;
        end
      end
    end else if (uw.act == ACT_INTEG) begin
      integ_acc <= integ_new;
    end
  end

  // Datapath working registers.
  always_ff @(posedge clk) begin
    if (uw.act == ACT_LATCH && adv) begin
      tgt_r  <= s_tdata[15:0];
      meas_r <= s_tdata[31:16];
      trim_r <= s_tdata[47:32];
    end
    if (uw.act == ACT_PREP) begin
      err_r  <= err;
      diff_r <= diff;
      sp_neg <= sp[16];
    end
    if (uw.act == ACT_KREG) begin
      kreg <= prod[31:0];
    end
    if (uw.act == ACT_MAG) begin
      mag <= mag_new;
    end
    if (uw.mul != MUL_NONE) begin
      prod <= mul_p;
    end
    case (uw.acc)
      ACC_CLEAR: acc <= '0;
      ACC_ADD0:  acc <= acc + 60'(prod);
      ACC_ADD7:  acc <= acc + (60'(prod) <<< 7);
      ACC_ADD11: acc <= acc + (60'(prod) <<< 11);
      default:   acc <= acc;
    endcase
  end

  // Result register: loaded at the final step once it is free.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if ((uw.act == ACT_EMIT_RUN || uw.act == ACT_EMIT_STOP) && adv) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (uw.act == ACT_EMIT_STOP && adv) begin
      out_duty   <= '0;
      out_dir_a  <= 1'b0;
      out_dir_b  <= 1'b0;
      out_level  <= '0;
      out_halted <= 1'b1;
    end else if (uw.act == ACT_EMIT_RUN && adv) begin
      out_duty   <= duty_new;
      out_dir_a  <= (mag != '0) && fwd;
      out_dir_b  <= (mag != '0) && !fwd;
      out_level  <= sp_neg ? -$signed(mag) : $signed(mag);
      out_halted <= 1'b0;
    end
  end

`ifndef SYNTHESIS
  a_accept_starts_prep: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> step == ST_PREP)
    else $error("accepted word did not start the preparation step");

  a_integ_in_range: assert property (@(posedge clk) disable iff (rst)
    (integ_acc <= 24'(INTEG_LIMIT)) && (integ_acc >= -24'(INTEG_LIMIT)))
    else $error("integral left its clamp range");

  a_halt_is_quiet: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && out_halted |->
      out_duty == '0 && out_level == '0 && !out_dir_a && !out_dir_b)
    else $error("stop result drives the motor");

  a_zero_level_quiet: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && out_level == '0 |-> out_duty == '0 && !out_dir_a && !out_dir_b)
    else $error("zero drive level with nonzero duty or pins");
`endif

endmodule

// ===== hdl/wspd_seq.sv =====
// Step counter and control store lookup of the wheel speed PID drive.
module wspd_seq (
  input  logic             clk,
  input  logic             rst,
  input  wspd_pkg::cond_t  cond,
  output wspd_pkg::step_t  step,
  output wspd_pkg::uword_t uw,
  output logic             adv
);
  import wspd_pkg::*;

  step_t step_next;

  always_comb begin
    uw        = rom_word(step);
    adv       = 1'b1;
    step_next = step + step_t'(1);
    unique case (uw.jmp)
      JMP_NEXT: begin
        step_next = step + step_t'(1);
      end
      JMP_WAIT_IN: begin
        adv       = cond.in_fire;
        step_next = cond.in_fire ? step + step_t'(1) : step;
      end
      JMP_IF_STOP: begin
        if (cond.stop) begin
          step_next = uw.dest;
        end
      end
      JMP_WAIT_OUT: begin
        adv       = cond.out_free;
        step_next = cond.out_free ? uw.dest : step;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= ST_IDLE;
    end else begin
      step <= step_next;
    end
  end

endmodule
